FILE: hw/rtl/cms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cms_pkg
// Types, register indexes and fixed-point constants of the cone momentum sum.
// ----------------------------------------------------------------------------
package cms_pkg;

   // field widths
   localparam int ETA_W      = 14;
   localparam int PHI_W      = 13;
   localparam int CENT_W     = 8;
   localparam int MOM_W      = 16;
   localparam int SUM_W      = 24;
   localparam int RADIUS_W   = 24;
   localparam int BIN_OUT_W  = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // default number of eta bins
   localparam int ETA_BINS_DEFAULT = 48;

   // phi in 1/1024 rad
   localparam int PHI_PI     = 3217;
   localparam int PHI_TWO_PI = 6434;

   // eta binning: (eta*10 + 24576) * bins / 49152, 49152 = 3 << 14
   localparam int ETA_SCALE   = 10;
   localparam int ETA_OFFSET  = 24576;
   localparam int ETA_SHIFT   = 14;
   localparam int DIV3_MUL    = 2731;  // floor(v/3) = (v*2731) >> 13 for v < 2048
   localparam int DIV3_SHIFT  = 13;

   // register reset values
   localparam logic [RADIUS_W-1:0] RADIUS_SQ_RESET = 24'd94372;
   localparam logic [CENT_W-1:0]   CENT_MIN_RESET  = 8'd0;
   localparam logic [CENT_W-1:0]   CENT_MAX_RESET  = 8'd4;

   // saturation bounds
   localparam logic [SUM_W-1:0] PT_SUM_MAX  = 24'hFFFFFF;
   localparam logic [SUM_W-1:0] SSUM_MAX    = 24'h7FFFFF;
   localparam logic [SUM_W-1:0] SSUM_MIN    = 24'h800000;

   typedef enum logic {
      OP_HEADER   = 1'b0,
      OP_PARTICLE = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONE_RADIUS_SQ = 2'd0,
      CSR_CENT_MIN       = 2'd1,
      CSR_CENT_MAX       = 2'd2
   } csr_index_type;

endpackage
`default_nettype wire

FILE: hw/rtl/cone_momentum_sum_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cone_momentum_sum_unit
// Per-event cone isolation sum: sums the momenta of particles within a squared
// radius of the cone centre and emits three saturating momentum sums per accepted event.
// ----------------------------------------------------------------------------
//
//  channel | ports            | handshake          | word
//  --------+------------------+--------------------+---------------------------
//  input   | req_*            | req_valid/ready    | header or particle
//  result  | rsp_*            | rsp_valid/ready    | sums, eta bin, saturated
//  config  | csr_*            | csr_we, no wait    | one register write
//
//  Timing: a word is held in the input register, where the cone test and
//  the sum update run, and a result lands in the output register at the
//  same edge as the sum update. The single accumulate loop (two squares, one
//  compare, saturating adds) sets a throughput of one word per clock, stalls aside.
//  Stalls: the input register also serves as the skid stage, so a word is
//  taken while a result waits; a word that would emit holds until the output
//  register frees. Reset: synchronous, active high; registers take their
//  reset values and the event state clears.
//
module cone_momentum_sum_unit #(
   parameter int ETA_BINS = cms_pkg::ETA_BINS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_opcode,
   input  wire logic [cms_pkg::CENT_W-1:0]           req_centrality,
   input  wire logic signed [cms_pkg::ETA_W-1:0]     req_eta,
   input  wire logic signed [cms_pkg::PHI_W-1:0]     req_phi,
   input  wire logic [cms_pkg::MOM_W-1:0]            req_pt,
   input  wire logic signed [cms_pkg::MOM_W-1:0]     req_sub_pt,
   input  wire logic signed [cms_pkg::MOM_W-1:0]     req_sub_initial_pt,
   input  wire logic                                 req_last,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [cms_pkg::SUM_W-1:0]                 rsp_pt_sum,
   output logic signed [cms_pkg::SUM_W-1:0]          rsp_sub_pt_sum,
   output logic signed [cms_pkg::SUM_W-1:0]          rsp_sub_initial_sum,
   output logic [cms_pkg::BIN_OUT_W-1:0]             rsp_eta_bin,
   output logic                                      rsp_saturated,

   input  wire logic                                 csr_we,
   input  wire logic [cms_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [cms_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import cms_pkg::*;

   // eta bin arithmetic widths
   localparam int BIN_W   = $clog2(ETA_BINS + 1);
   localparam int ETA_U_W = 17;                       // eta*10 + offset, non-negative
   localparam int PROD_W  = ETA_U_W + BIN_W;
   localparam int V_W     = PROD_W - ETA_SHIFT;
   localparam int DIV3_W  = V_W + 12;
   localparam int Q_W     = DIV3_W - DIV3_SHIFT;
   localparam logic [Q_W-1:0] BIN_LAST = Q_W'(ETA_BINS - 1);

   // ---------------------------------------------------------------- config
   logic [RADIUS_W-1:0] radius_sq_ff;
   logic [CENT_W-1:0]   cent_min_ff;
   logic [CENT_W-1:0]   cent_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_sq_ff <= RADIUS_SQ_RESET;
         cent_min_ff  <= CENT_MIN_RESET;
         cent_max_ff  <= CENT_MAX_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CONE_RADIUS_SQ: radius_sq_ff <= csr_wdata[RADIUS_W-1:0];
            CSR_CENT_MIN:       cent_min_ff  <= csr_wdata[CENT_W-1:0];
            CSR_CENT_MAX:       cent_max_ff  <= csr_wdata[CENT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // --------------------------------------------------------- input register
   logic                  in_valid_ff;
   logic                  in_opcode_ff;
   logic [CENT_W-1:0]     in_cent_ff;
   logic [ETA_W-1:0]      in_eta_ff;
   logic [PHI_W-1:0]      in_phi_ff;
   logic [MOM_W-1:0]      in_pt_ff;
   logic [MOM_W-1:0]      in_sub_ff;
   logic [MOM_W-1:0]      in_init_ff;
   logic                  in_last_ff;

   logic                  process;   // word in the input register completes
   logic                  emit;      // completing word yields a result
   logic                  rsp_valid_ff;

   assign req_ready = !in_valid_ff || process;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_opcode_ff <= req_opcode;
         in_cent_ff   <= req_centrality;
         in_eta_ff    <= req_eta;
         in_phi_ff    <= req_phi;
         in_pt_ff     <= req_pt;
         in_sub_ff    <= req_sub_pt;
         in_init_ff   <= req_sub_initial_pt;
         in_last_ff   <= req_last;
      end
   end

   // ----------------------------------------------------------- event state
   logic [ETA_W-1:0]  centre_eta_ff,  centre_eta_in;
   logic [PHI_W-1:0]  centre_phi_ff,  centre_phi_in;
   logic              accepted_ff,    accepted_in;
   logic [SUM_W-1:0]  sum_pt_ff,      sum_pt_in;
   logic [SUM_W-1:0]  sum_sub_ff,     sum_sub_in;
   logic [SUM_W-1:0]  sum_init_ff,    sum_init_in;
   logic              clip_ff,        clip_in;

   logic is_header;
   logic cent_ok;
   logic acc_eff;     // acceptance seen by this word (header sets it first)

   assign is_header = (in_opcode_ff == OP_HEADER);
   assign cent_ok   = (in_cent_ff >= cent_min_ff) && (in_cent_ff < cent_max_ff);
   assign acc_eff   = is_header ? cent_ok : accepted_ff;
   assign emit      = in_last_ff && acc_eff;
   assign process   = in_valid_ff && (!emit || !rsp_valid_ff || rsp_ready);

   // cone test: exact squared distance, dphi folded into 0..pi
   logic [ETA_W:0]     deta;
   logic [ETA_W-1:0]   deta_mag;
   logic [PHI_W:0]     dphi;
   logic [PHI_W-1:0]   dphi_abs;
   logic [PHI_W-1:0]   dphi_mag;
   logic [2*ETA_W-1:0] deta_sq;
   logic [2*PHI_W-1:0] dphi_sq;
   logic [2*ETA_W:0]   dist_sq;
   logic               in_cone;

   always_comb begin
      deta     = {in_eta_ff[ETA_W-1], in_eta_ff} - {centre_eta_ff[ETA_W-1], centre_eta_ff};
      deta_mag = deta[ETA_W] ? ETA_W'(-deta) : deta[ETA_W-1:0];
      dphi     = {in_phi_ff[PHI_W-1], in_phi_ff} - {centre_phi_ff[PHI_W-1], centre_phi_ff};
      dphi_abs = dphi[PHI_W] ? PHI_W'(-dphi) : dphi[PHI_W-1:0];
      if (dphi_abs > PHI_W'(PHI_PI)) begin
         // only the square is used, so fold to a magnitude either way
         if (dphi_abs >= PHI_W'(PHI_TWO_PI)) begin
            dphi_mag = dphi_abs - PHI_W'(PHI_TWO_PI);
         end else begin
            dphi_mag = PHI_W'(PHI_TWO_PI) - dphi_abs;
         end
      end else begin
         dphi_mag = dphi_abs;
      end
      deta_sq = deta_mag * deta_mag;
      dphi_sq = dphi_mag * dphi_mag;
      dist_sq = {1'b0, deta_sq} + (2*ETA_W+1)'(dphi_sq);
      in_cone = dist_sq < (2*ETA_W+1)'(radius_sq_ff);
   end

   // saturating adds
   logic [SUM_W:0] pt_raw, sub_raw, init_raw;
   logic [SUM_W-1:0] pt_sat, sub_sat, init_sat;
   logic pt_clip, sub_clip, init_clip;

   always_comb begin
      pt_raw   = {1'b0, sum_pt_ff} + (SUM_W+1)'(in_pt_ff);
      sub_raw  = {sum_sub_ff[SUM_W-1], sum_sub_ff}
               + {{(SUM_W+1-MOM_W){in_sub_ff[MOM_W-1]}}, in_sub_ff};
      init_raw = {sum_init_ff[SUM_W-1], sum_init_ff}
               + {{(SUM_W+1-MOM_W){in_init_ff[MOM_W-1]}}, in_init_ff};

      pt_clip   = pt_raw[SUM_W];
      sub_clip  = sub_raw[SUM_W] != sub_raw[SUM_W-1];
      init_clip = init_raw[SUM_W] != init_raw[SUM_W-1];

      pt_sat   = pt_clip ? PT_SUM_MAX : pt_raw[SUM_W-1:0];
      sub_sat  = sub_clip ? (sub_raw[SUM_W] ? SSUM_MIN : SSUM_MAX) : sub_raw[SUM_W-1:0];
      init_sat = init_clip ? (init_raw[SUM_W] ? SSUM_MIN : SSUM_MAX) : init_raw[SUM_W-1:0];
   end

   // next event state
   always_comb begin
      centre_eta_in = centre_eta_ff;
      centre_phi_in = centre_phi_ff;
      accepted_in   = accepted_ff;
      sum_pt_in     = sum_pt_ff;
      sum_sub_in    = sum_sub_ff;
      sum_init_in   = sum_init_ff;
      clip_in       = clip_ff;
      if (is_header) begin
         // a header restarts the event, even mid-event
         centre_eta_in = in_eta_ff;
         centre_phi_in = in_phi_ff;
         accepted_in   = cent_ok;
         sum_pt_in     = '0;
         sum_sub_in    = '0;
         sum_init_in   = '0;
         clip_in       = 1'b0;
      end else if (accepted_ff && in_cone) begin
         sum_pt_in   = pt_sat;
         sum_sub_in  = sub_sat;
         sum_init_in = init_sat;
         clip_in     = clip_ff || pt_clip || sub_clip || init_clip;
      end
      // after emission, stray particles are ignored until the next header
      if (emit) begin
         accepted_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_eta_ff <= '0;
         centre_phi_ff <= '0;
         accepted_ff   <= 1'b0;
         sum_pt_ff     <= '0;
         sum_sub_ff    <= '0;
         sum_init_ff   <= '0;
         clip_ff       <= 1'b0;
      end else if (process) begin
         centre_eta_ff <= centre_eta_in;
         centre_phi_ff <= centre_phi_in;
         accepted_ff   <= accepted_in;
         sum_pt_ff     <= sum_pt_in;
         sum_sub_ff    <= sum_sub_in;
         sum_init_ff   <= sum_init_in;
         clip_ff       <= clip_in;
      end
   end

   // eta bin of the cone centre as seen by this word
   logic [ETA_W-1:0]   bin_eta;
   logic signed [ETA_U_W:0] eta_lin;
   logic [PROD_W-1:0]  bin_prod;
   logic [V_W-1:0]     bin_v;
   logic [DIV3_W-1:0]  bin_div;
   logic [Q_W-1:0]     bin_q;
   logic [Q_W-1:0]     bin_clamped;

   always_comb begin
      bin_eta  = is_header ? in_eta_ff : centre_eta_ff;
      eta_lin  = (ETA_U_W+1)'($signed(bin_eta)) * (ETA_U_W+1)'(ETA_SCALE)
               + (ETA_U_W+1)'(ETA_OFFSET);
      if (eta_lin[ETA_U_W]) begin
         bin_prod = '0;
      end else begin
         bin_prod = PROD_W'(eta_lin[ETA_U_W-1:0]) * PROD_W'(ETA_BINS);
      end
      bin_v       = bin_prod[PROD_W-1:ETA_SHIFT];
      bin_div     = DIV3_W'(bin_v) * DIV3_W'(DIV3_MUL);
      bin_q       = bin_div[DIV3_W-1:DIV3_SHIFT];
      bin_clamped = (bin_q > BIN_LAST) ? BIN_LAST : bin_q;
   end

   // ------------------------------------------------------- output register
   logic [SUM_W-1:0]     rsp_pt_ff, rsp_sub_ff, rsp_init_ff;
   logic [BIN_OUT_W-1:0] rsp_bin_ff;
   logic                 rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (process && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (process && emit) begin
         rsp_pt_ff   <= sum_pt_in;
         rsp_sub_ff  <= sum_sub_in;
         rsp_init_ff <= sum_init_in;
         rsp_bin_ff  <= bin_clamped[BIN_OUT_W-1:0];
         rsp_sat_ff  <= clip_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pt_sum          = rsp_pt_ff;
   assign rsp_sub_pt_sum      = rsp_sub_ff;
   assign rsp_sub_initial_sum = rsp_init_ff;
   assign rsp_eta_bin         = rsp_bin_ff;
   assign rsp_saturated       = rsp_sat_ff;

   // ------------------------------------------------------------ assertions
   // an emitted event closes: no second result before the next header
   a_close_on_emit: assert property (@(posedge clock) disable iff (reset)
      process && emit |=> !accepted_ff)
      else $error("event still open after its result");

   // a header leaves empty sums and no clip
   a_header_clears: assert property (@(posedge clock) disable iff (reset)
      process && is_header |=> (sum_pt_ff == '0) && (sum_sub_ff == '0)
                               && (sum_init_ff == '0) && !clip_ff)
      else $error("header did not clear the sums");

   // the pt sum never falls within an event
   a_pt_monotone: assert property (@(posedge clock) disable iff (reset)
      process && !is_header |=> sum_pt_ff >= $past(sum_pt_ff))
      else $error("pt sum decreased on a particle");

endmodule
`default_nettype wire
